// ----- rtl/core/ttt_pkg.sv -----
package ttt_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_template;
	} tok_in_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [2:0]  action_type;
		logic [15:0] span_start;
		logic [15:0] span_end;
		logic [11:0] opener_index;
		logic [3:0]  error_code;
		logic        last_record;
	} tok_rec_t;

	typedef struct packed {
		logic     two;
		tok_rec_t rec1;
		tok_rec_t rec0;
	} tok_bundle_t;

	localparam logic [1:0] REC_TEXT   = 2'd0;
	localparam logic [1:0] REC_ACTION = 2'd1;
	localparam logic [1:0] REC_ERROR  = 2'd2;

	localparam logic [2:0] ACT_TAG      = 3'd0;
	localparam logic [2:0] ACT_UNESC    = 3'd1;
	localparam logic [2:0] ACT_OPEN     = 3'd2;
	localparam logic [2:0] ACT_CLOSE    = 3'd3;
	localparam logic [2:0] ACT_INVERTED = 3'd4;
	localparam logic [2:0] ACT_COMMENT  = 3'd5;
	localparam logic [2:0] ACT_PARTIAL  = 3'd6;
	localparam logic [2:0] KIND_BRACE_UNESC = 3'd7;
	localparam logic [2:0] PREV_NONE        = 3'd7;

	localparam logic [3:0] ERR_BAD_START    = 4'd0;
	localparam logic [3:0] ERR_UNCLOSED     = 4'd1;
	localparam logic [3:0] ERR_STRAY_CLOSE  = 4'd2;
	localparam logic [3:0] ERR_MISMATCH     = 4'd3;
	localparam logic [3:0] ERR_COMMENT      = 4'd4;
	localparam logic [3:0] ERR_UNESC        = 4'd5;
	localparam logic [3:0] ERR_DELIMITER    = 4'd6;
	localparam logic [3:0] ERR_UNTERMINATED = 4'd7;
	localparam logic [3:0] ERR_INV_CONTENT  = 4'd8;
	localparam logic [3:0] ERR_NAME_LONG    = 4'd9;
	localparam logic [3:0] ERR_OVERFLOW     = 4'd10;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage

// ----- rtl/core/template_tag_tokenizer_top.sv -----
// Channel   Direction  Handshake                     Payload
// byte      in         byte_valid / byte_stall       byte_req (tok_in_t)
// rec       out        rec_valid / rec_stall         rec (tok_rec_t)
//
// One template byte is taken per cycle; the front scanner stalls only while its two-entry
// request queue to the record stage is full.
// Records leave one per cycle while rec_stall is low; of a byte that yields two records, the second
// waits in a pending register. A record passes through a queue entry and the output register to rec.
// Reset clears all control state; the section name and entry memories are not cleared.
module template_tag_tokenizer_top import ttt_pkg::*; #(
	parameter int STACK_DEPTH = 8,
	parameter int NAME_MAX    = 32,
	parameter int POS_BITS    = 16,
	parameter int ACTION_BITS = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  tok_in_t  byte_req,
	output logic     rec_valid,
	input  logic     rec_stall,
	output tok_rec_t rec
);

	logic        acc, push, pop, not_empty, full;
	tok_bundle_t bundle, head;

	assign byte_stall = full;
	assign acc        = byte_valid && !full;

	ttt_front #(
		.STACK_DEPTH (STACK_DEPTH),
		.NAME_MAX    (NAME_MAX),
		.POS_BITS    (POS_BITS),
		.ACTION_BITS (ACTION_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.item   (byte_req),
		.push   (push),
		.bundle (bundle)
	);

	ttt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	ttt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec       (rec)
	);

endmodule

// ----- rtl/core/ttt_ram.sv -----
module ttt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/ttt_front.sv -----
module ttt_front import ttt_pkg::*; #(
	parameter int STACK_DEPTH = 8,
	parameter int NAME_MAX    = 32,
	parameter int POS_BITS    = 16,
	parameter int ACTION_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  tok_in_t     item,
	output logic        push,
	output tok_bundle_t bundle
);

	localparam int LW     = $clog2(NAME_MAX + 2);
	localparam int DW     = $clog2(STACK_DEPTH + 1);
	localparam int SA     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int NI     = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
	localparam int NDEPTH = STACK_DEPTH * NAME_MAX;
	localparam int NA     = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
	localparam int EW     = LW + ACTION_BITS;

	localparam logic [3:0] PH_TEXT     = 4'd0;
	localparam logic [3:0] PH_BRACE    = 4'd1;
	localparam logic [3:0] PH_LEAD     = 4'd2;
	localparam logic [3:0] PH_PRENAME  = 4'd3;
	localparam logic [3:0] PH_NAME     = 4'd4;
	localparam logic [3:0] PH_POSTNAME = 4'd5;
	localparam logic [3:0] PH_CLOSE2   = 4'd6;
	localparam logic [3:0] PH_CLOSE3   = 4'd7;
	localparam logic [3:0] PH_COMMENT  = 4'd8;
	localparam logic [3:0] PH_COMMENT2 = 4'd9;
	localparam logic [3:0] PH_DRAIN    = 4'd10;

	logic [POS_BITS-1:0]    pos_q, pos_n, frag_q, frag_n, nstart_q, nstart_n;
	logic [3:0]             phase_q, phase_n;
	logic [2:0]             kind_q, kind_n, prev_q, prev_n;
	logic [LW-1:0]          nlen_q, nlen_n;
	logic [DW-1:0]          depth_q, depth_n;
	logic [ACTION_BITS-1:0] act_q, act_n;
	logic                   mism_q, mism_n;

	logic [3:0]    phase_d;
	logic [LW-1:0] nlen_d;
	logic [DW-1:0] depth_d;
	logic [SA-1:0] top_d;
	logic [NI-1:0] ridx;

	logic          nwr_en, lwr_en;
	logic [NA-1:0] nwr_addr, nrd_addr;
	logic [7:0]    rd_name;
	logic [EW-1:0] rd_ent;
	logic [LW-1:0] rd_len;
	logic [ACTION_BITS-1:0] rd_idx;
	logic [LW-1:0] aidx;

	function automatic tok_rec_t mk_rec(input logic [1:0] k, input logic [2:0] t,
		input logic [15:0] s, input logic [15:0] e, input logic [11:0] o,
		input logic [3:0] ec, input logic lst);
		tok_rec_t r;
		r.record_kind  = k;
		r.action_type  = t;
		r.span_start   = s;
		r.span_end     = e;
		r.opener_index = o;
		r.error_code   = ec;
		r.last_record  = lst;
		return r;
	endfunction

	assign rd_len = rd_ent[EW-1:ACTION_BITS];
	assign rd_idx = rd_ent[ACTION_BITS-1:0];

	always_comb begin
		logic [7:0]          c;
		logic                drained, app, app_first, fin, fail;
		logic [3:0]          fcode;
		logic [2:0]          ftype;
		logic [POS_BITS-1:0] fe, endp;
		tok_rec_t            recs [2];
		logic [1:0]          cnt;

		c         = item.byte_in;
		drained   = (phase_q == PH_DRAIN);
		app       = 1'b0;
		app_first = 1'b0;
		fin       = 1'b0;
		fail      = 1'b0;
		fcode     = ERR_BAD_START;
		ftype     = ACT_TAG;
		fe        = frag_q;
		endp      = pos_q + POS_BITS'(1);
		recs[0]   = '0;
		recs[1]   = '0;
		cnt       = 2'd0;
		aidx      = '0;
		nwr_en    = 1'b0;
		lwr_en    = 1'b0;

		pos_n    = pos_q;
		frag_n   = frag_q;
		phase_n  = phase_q;
		kind_n   = kind_q;
		nstart_n = nstart_q;
		nlen_n   = nlen_q;
		depth_n  = depth_q;
		act_n    = act_q;
		prev_n   = prev_q;
		mism_n   = mism_q;

		unique case (phase_q)
			PH_TEXT: begin
				if (c == CH_LBRACE) begin
					phase_n = PH_BRACE;
				end
			end
			PH_BRACE: begin
				if (c == CH_LBRACE) begin
					recs[0] = mk_rec(REC_TEXT, ACT_TAG, 16'(frag_q),
						16'(pos_q - POS_BITS'(1)), 12'd0, ERR_BAD_START, 1'b0);
					cnt = 2'd1;
					phase_n = PH_LEAD;
				end else begin
					phase_n = PH_TEXT;
				end
			end
			PH_LEAD: begin
				if (!is_space(c)) begin
					priority if (c == CH_HASH) begin
						kind_n = ACT_OPEN;
						phase_n = PH_PRENAME;
					end else if (c == CH_CARET) begin
						kind_n = ACT_INVERTED;
						phase_n = PH_PRENAME;
					end else if (c == CH_GT) begin
						kind_n = ACT_PARTIAL;
						phase_n = PH_PRENAME;
					end else if (c == CH_AMP) begin
						kind_n = ACT_UNESC;
						phase_n = PH_PRENAME;
					end else if (c == CH_LBRACE) begin
						kind_n = KIND_BRACE_UNESC;
						phase_n = PH_PRENAME;
					end else if (c == CH_SLASH) begin
						if (depth_q == '0) begin
							fail = 1'b1;
							fcode = ERR_STRAY_CLOSE;
						end else begin
							kind_n = ACT_CLOSE;
							phase_n = PH_PRENAME;
						end
					end else if (c == CH_BANG) begin
						kind_n = ACT_COMMENT;
						nstart_n = pos_q + POS_BITS'(1);
						phase_n = PH_COMMENT;
					end else if (c == CH_EQ) begin
						fail = 1'b1;
						fcode = ERR_DELIMITER;
					end else begin
						kind_n = ACT_TAG;
						if (is_alpha(c) || c == CH_UNDER) begin
							app = 1'b1;
							app_first = 1'b1;
						end else begin
							fail = 1'b1;
							fcode = ERR_BAD_START;
						end
					end
				end
			end
			PH_PRENAME: begin
				if (!is_space(c)) begin
					if (is_alpha(c) || c == CH_UNDER) begin
						app = 1'b1;
						app_first = 1'b1;
					end else begin
						fail = 1'b1;
						fcode = ERR_BAD_START;
					end
				end
			end
			PH_NAME: begin
				if (is_alpha(c) || is_digit(c) || c == CH_UNDER ||
					(kind_q == ACT_PARTIAL && (c == CH_SLASH || c == CH_DOT))) begin
					app = 1'b1;
				end else begin
					frag_n = pos_q;
					priority if (is_space(c)) begin
						phase_n = PH_POSTNAME;
					end else if (c == CH_RBRACE) begin
						phase_n = PH_CLOSE2;
					end else begin
						fail = 1'b1;
						fcode = ERR_UNCLOSED;
					end
				end
			end
			PH_POSTNAME: begin
				if (!is_space(c)) begin
					if (c == CH_RBRACE) begin
						phase_n = PH_CLOSE2;
					end else begin
						fail = 1'b1;
						fcode = ERR_UNCLOSED;
					end
				end
			end
			PH_CLOSE2: begin
				priority if (c != CH_RBRACE) begin
					fail = 1'b1;
					fcode = ERR_UNCLOSED;
				end else if (kind_q == KIND_BRACE_UNESC) begin
					phase_n = PH_CLOSE3;
				end else begin
					fin = 1'b1;
				end
			end
			PH_CLOSE3: begin
				if (c == CH_RBRACE) begin
					fin = 1'b1;
				end else begin
					fail = 1'b1;
					fcode = ERR_UNESC;
				end
			end
			PH_COMMENT: begin
				if (c == CH_RBRACE) begin
					phase_n = PH_COMMENT2;
				end
			end
			PH_COMMENT2: begin
				if (c == CH_RBRACE) begin
					fin = 1'b1;
				end else begin
					phase_n = PH_COMMENT;
				end
			end
			default: begin
				phase_n = PH_DRAIN;
			end
		endcase

		if (app) begin
			aidx = app_first ? '0 : nlen_q;
			if (app_first) begin
				nstart_n = pos_q;
				nlen_n = LW'(1);
				phase_n = PH_NAME;
			end else if (nlen_q <= LW'(NAME_MAX)) begin
				nlen_n = nlen_q + LW'(1);
			end
			if ((kind_n == ACT_OPEN || kind_n == ACT_INVERTED) && aidx < LW'(NAME_MAX) &&
				depth_q < DW'(STACK_DEPTH)) begin
				nwr_en = 1'b1;
			end
			if (kind_n == ACT_CLOSE && aidx < LW'(NAME_MAX)) begin
				mism_n = (app_first ? 1'b0 : mism_q) | (c != rd_name);
			end else if (app_first) begin
				mism_n = 1'b0;
			end
		end

		if (fin) begin
			ftype = (kind_q == KIND_BRACE_UNESC) ? ACT_UNESC : kind_q;
			fe = (ftype == ACT_COMMENT) ? pos_q - POS_BITS'(1) : frag_q;
			priority if (ftype == ACT_CLOSE && depth_q == '0) begin
				fail = 1'b1;
				fcode = ERR_STRAY_CLOSE;
			end else if (ftype == ACT_CLOSE &&
				(nlen_q > LW'(NAME_MAX) || nlen_q != rd_len || mism_q)) begin
				fail = 1'b1;
				fcode = ERR_MISMATCH;
			end else if ((ftype == ACT_OPEN || ftype == ACT_INVERTED) &&
				nlen_q > LW'(NAME_MAX)) begin
				fail = 1'b1;
				fcode = ERR_NAME_LONG;
			end else if ((ftype == ACT_OPEN || ftype == ACT_INVERTED) &&
				depth_q >= DW'(STACK_DEPTH)) begin
				fail = 1'b1;
				fcode = ERR_OVERFLOW;
			end else if (prev_q == ACT_INVERTED && ftype != ACT_CLOSE) begin
				fail = 1'b1;
				fcode = ERR_INV_CONTENT;
			end else begin
				recs[cnt[0]] = mk_rec(REC_ACTION, ftype, 16'(nstart_q), 16'(fe),
					(ftype == ACT_CLOSE) ? 12'(rd_idx) : 12'd0, ERR_BAD_START, 1'b0);
				cnt = cnt + 2'd1;
				if (ftype == ACT_OPEN || ftype == ACT_INVERTED) begin
					lwr_en = 1'b1;
					depth_n = depth_q + DW'(1);
				end else if (ftype == ACT_CLOSE) begin
					depth_n = depth_q - DW'(1);
				end
				prev_n = ftype;
				act_n = act_q + ACTION_BITS'(1);
				frag_n = pos_q + POS_BITS'(1);
				phase_n = PH_TEXT;
			end
		end

		if (fail) begin
			recs[cnt[0]] = mk_rec(REC_ERROR, ACT_TAG, 16'(pos_q), 16'(pos_q + POS_BITS'(1)),
				12'd0, fcode, 1'b1);
			cnt = cnt + 2'd1;
			phase_n = PH_DRAIN;
		end

		if (phase_n == PH_DRAIN && !drained) begin
			pos_n = pos_q + POS_BITS'(1);
		end else if (!item.end_of_template) begin
			pos_n = pos_q + POS_BITS'(1);
		end else if (!drained) begin
			fail = 1'b0;
			unique case (phase_n)
				PH_TEXT, PH_BRACE: begin
					if (depth_n != '0) begin
						fail = 1'b1;
						fcode = ERR_UNTERMINATED;
					end else if (frag_n != endp) begin
						recs[cnt[0]] = mk_rec(REC_TEXT, ACT_TAG, 16'(frag_n), 16'(endp),
							12'd0, ERR_BAD_START, 1'b0);
						cnt = cnt + 2'd1;
					end
				end
				PH_LEAD, PH_PRENAME: begin
					fail = 1'b1;
					fcode = ERR_BAD_START;
				end
				PH_CLOSE3: begin
					fail = 1'b1;
					fcode = ERR_UNESC;
				end
				PH_COMMENT, PH_COMMENT2: begin
					fail = 1'b1;
					fcode = ERR_COMMENT;
				end
				default: begin
					fail = 1'b1;
					fcode = ERR_UNCLOSED;
				end
			endcase
			if (fail) begin
				recs[cnt[0]] = mk_rec(REC_ERROR, ACT_TAG, 16'(pos_q),
					16'(pos_q + POS_BITS'(1)), 12'd0, fcode, 1'b1);
				cnt = cnt + 2'd1;
			end
			if (cnt == 2'd2) begin
				recs[1].last_record = 1'b1;
			end else if (cnt == 2'd1) begin
				recs[0].last_record = 1'b1;
			end
		end

		if (item.end_of_template) begin
			pos_n    = '0;
			frag_n   = '0;
			phase_n  = PH_TEXT;
			kind_n   = ACT_TAG;
			nstart_n = '0;
			nlen_n   = '0;
			depth_n  = '0;
			act_n    = '0;
			prev_n   = PREV_NONE;
			mism_n   = 1'b0;
		end

		push        = acc && (cnt != 2'd0);
		bundle.rec0 = recs[0];
		bundle.rec1 = recs[1];
		bundle.two  = (cnt == 2'd2);
	end

	assign phase_d = acc ? phase_n : phase_q;
	assign nlen_d  = acc ? nlen_n : nlen_q;
	assign depth_d = acc ? depth_n : depth_q;
	assign top_d   = (depth_d == '0) ? '0 : SA'(depth_d - DW'(1));
	assign ridx    = (phase_d == PH_NAME && nlen_d < LW'(NAME_MAX)) ? nlen_d[NI-1:0] : '0;

	assign nrd_addr = NA'(top_d) * NA'(NAME_MAX) + NA'(ridx);
	assign nwr_addr = NA'(depth_q[SA-1:0]) * NA'(NAME_MAX) + NA'(aidx[NI-1:0]);

	ttt_ram #(.WIDTH(8), .DEPTH(NDEPTH)) u_names (
		.clk     (clk),
		.wr_en   (acc && nwr_en),
		.wr_addr (nwr_addr),
		.wr_data (item.byte_in),
		.rd_addr (nrd_addr),
		.rd_data (rd_name)
	);

	ttt_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_entries (
		.clk     (clk),
		.wr_en   (acc && lwr_en),
		.wr_addr (depth_q[SA-1:0]),
		.wr_data ({nlen_q, act_q}),
		.rd_addr (top_d),
		.rd_data (rd_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			frag_q   <= '0;
			phase_q  <= PH_TEXT;
			kind_q   <= ACT_TAG;
			nstart_q <= '0;
			nlen_q   <= '0;
			depth_q  <= '0;
			act_q    <= '0;
			prev_q   <= PREV_NONE;
			mism_q   <= 1'b0;
		end else if (acc) begin
			pos_q    <= pos_n;
			frag_q   <= frag_n;
			phase_q  <= phase_n;
			kind_q   <= kind_n;
			nstart_q <= nstart_n;
			nlen_q   <= nlen_n;
			depth_q  <= depth_n;
			act_q    <= act_n;
			prev_q   <= prev_n;
			mism_q   <= mism_n;
		end
	end

endmodule

// ----- rtl/core/ttt_queue.sv -----
module ttt_queue import ttt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tok_bundle_t push_data,
	input  logic        pop,
	output tok_bundle_t head,
	output logic        not_empty,
	output logic        full
);

	tok_bundle_t ent_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;

	assign head      = ent_q[rd_ptr_q];
	assign not_empty = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && not_empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && not_empty);
		end
	end

endmodule

// ----- rtl/core/ttt_back.sv -----
module ttt_back import ttt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tok_bundle_t head,
	input  logic        not_empty,
	output logic        pop,
	output logic        rec_valid,
	input  logic        rec_stall,
	output tok_rec_t    rec
);

	tok_rec_t out_q, pend_q;
	logic     out_valid_q, pend_valid_q;
	logic     load;

	assign load      = !out_valid_q || !rec_stall;
	assign pop       = load && !pend_valid_q && not_empty;
	assign rec_valid = out_valid_q;
	assign rec       = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (not_empty) begin
				out_q  <= head.rec0;
				pend_q <= head.rec1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= not_empty;
				pend_valid_q <= not_empty && head.two;
			end
		end
	end

endmodule

// ----- rtl/core/ttt_checker.sv -----
module ttt_checker import ttt_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     byte_valid,
	input logic     byte_stall,
	input tok_in_t  byte_req,
	input logic     rec_valid,
	input logic     rec_stall,
	input tok_rec_t rec
);

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> rec_valid && $stable(rec))
		else $error("stalled record changed");

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_req))
		else $error("stalled request changed");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec.record_kind == REC_ERROR |-> rec.last_record && rec.opener_index == 12'd0)
		else $error("error record not final");

	a_text_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec.record_kind == REC_TEXT |->
			rec.action_type == ACT_TAG && rec.error_code == ERR_BAD_START &&
			rec.opener_index == 12'd0)
		else $error("text fragment carries action fields");

	a_action_type: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec.record_kind == REC_ACTION |->
			rec.action_type != KIND_BRACE_UNESC && rec.error_code == ERR_BAD_START)
		else $error("bad action record");

endmodule

bind template_tag_tokenizer_top ttt_checker u_ttt_checker (.*);
